@@ rtl/irpd_pkg.sv @@
// Shared types, codes and reset values for the IR pulse-distance frame decoder.
package irpd_pkg;

	localparam int PHASE_W         = 7;
	localparam int TICK_W          = 16;
	localparam int CFG_IDX_W       = 3;
	localparam int FRAME_BYTES_DEF = 13;
	localparam int FRAME_LO_W      = 64;
	localparam int FRAME_HI_W      = 40;

	typedef enum logic [2:0] {
		ST_ARMED     = 3'd0,
		ST_NO_LEADER = 3'd1,
		ST_LEADER    = 3'd2,
		ST_BIT       = 3'd3,
		ST_BAD_BIT   = 3'd4,
		ST_DONE      = 3'd5
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEADER_MIN = 3'd0,
		REG_LEADER_MAX = 3'd1,
		REG_ZERO_MIN   = 3'd2,
		REG_ZERO_MAX   = 3'd3,
		REG_ONE_MIN    = 3'd4,
		REG_ONE_MAX    = 3'd5
	} reg_idx_t;

	localparam logic [TICK_W-1:0] LEADER_MIN_RST = 16'd12922;
	localparam logic [TICK_W-1:0] LEADER_MAX_RST = 16'd13998;
	localparam logic [TICK_W-1:0] ZERO_MIN_RST   = 16'd1076;
	localparam logic [TICK_W-1:0] ZERO_MAX_RST   = 16'd1164;
	localparam logic [TICK_W-1:0] ONE_MIN_RST    = 16'd2147;
	localparam logic [TICK_W-1:0] ONE_MAX_RST    = 16'd2325;

	// window thresholds as configured
	typedef struct packed {
		logic [TICK_W-1:0] leader_min;
		logic [TICK_W-1:0] leader_max;
		logic [TICK_W-1:0] zero_min;
		logic [TICK_W-1:0] zero_max;
		logic [TICK_W-1:0] one_min;
		logic [TICK_W-1:0] one_max;
	} win_cfg_t;

	// which windows the interval falls into
	typedef struct packed {
		logic leader;
		logic zero;
		logic one;
	} win_hit_t;

endpackage

@@ rtl/irpd_window.sv @@
// Window compares that classify one interval as leader, bit zero or bit one.
module irpd_window import irpd_pkg::*; (
	input  logic [TICK_W-1:0] interval,
	input  win_cfg_t          cfg,
	output win_hit_t          hit
);

	// inclusive bounds; an empty window (min above max) never matches
	assign hit.leader = (interval >= cfg.leader_min) && (interval <= cfg.leader_max);
	assign hit.zero   = (interval >= cfg.zero_min) && (interval <= cfg.zero_max);
	assign hit.one    = (interval >= cfg.one_min) && (interval <= cfg.one_max);

endmodule

@@ rtl/ir_pulse_distance_frame_decoder.sv @@
// Top level of the IR pulse-distance frame decoder.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  input    | in_valid / in_stall        | interval_ticks[15:0]
//  output   | out_valid / out_stall      | status[2:0], frame_low, frame_high
//  config   | cfg_valid / cfg_ready      | cfg_index[2:0], cfg_data[15:0]
//
// One interval per cycle sustained while the output is not stalled; an item passes from
// the input register to the result register, with the window compare and byte shift between them.
// Reset clears the phase counter to idle and loads the default windows.
// The frame bytes are not reset; every completed frame rewrites all of them.
// An output stall holds the result register and, through it, the input register.
module ir_pulse_distance_frame_decoder import irpd_pkg::*; #(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [TICK_W-1:0]       interval_ticks,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [2:0]              status,
	output logic [FRAME_LO_W-1:0]   frame_low,
	output logic [FRAME_HI_W-1:0]   frame_high,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [TICK_W-1:0]       cfg_data
);

	localparam int IDX_W = $clog2(FRAME_BYTES);
	localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(2 + FRAME_BYTES * 8 - 1);
	localparam logic [PHASE_W-1:0] PH_IDLE    = PHASE_W'(0);
	localparam logic [PHASE_W-1:0] PH_LEADER  = PHASE_W'(1);
	localparam logic [PHASE_W-1:0] PH_FIRST   = PHASE_W'(2);

	win_cfg_t            cfg_q;
	logic                valid_s1;
	logic [TICK_W-1:0]   interval_s1;
	logic [PHASE_W-1:0]  phase_q;
	logic [7:0]          store_q [FRAME_BYTES];
	logic                out_valid_q;
	status_t             status_q;
	logic [FRAME_LO_W-1:0] frame_low_q;
	logic [FRAME_HI_W-1:0] frame_high_q;

	win_hit_t            hit;
	logic                advance;
	logic [PHASE_W-1:0]  bit_n;
	logic [IDX_W-1:0]    byte_idx;
	logic [7:0]          rd_byte;
	logic [7:0]          new_byte;
	logic                wr_en;
	logic                done;
	status_t             st;
	logic [PHASE_W-1:0]  nxt_phase;
	logic [FRAME_LO_W-1:0] lo_d;
	logic [FRAME_HI_W-1:0] hi_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.leader_min <= LEADER_MIN_RST;
			cfg_q.leader_max <= LEADER_MAX_RST;
			cfg_q.zero_min   <= ZERO_MIN_RST;
			cfg_q.zero_max   <= ZERO_MAX_RST;
			cfg_q.one_min    <= ONE_MIN_RST;
			cfg_q.one_max    <= ONE_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LEADER_MIN: cfg_q.leader_min <= cfg_data;
				REG_LEADER_MAX: cfg_q.leader_max <= cfg_data;
				REG_ZERO_MIN:   cfg_q.zero_min   <= cfg_data;
				REG_ZERO_MAX:   cfg_q.zero_max   <= cfg_data;
				REG_ONE_MIN:    cfg_q.one_min    <= cfg_data;
				REG_ONE_MAX:    cfg_q.one_max    <= cfg_data;
				default: ;
			endcase
		end
	end

	// s1 moves on when the result register is empty or being drained
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			interval_s1 <= interval_ticks;
		end
	end

	irpd_window u_window (
		.interval (interval_s1),
		.cfg      (cfg_q),
		.hit      (hit)
	);

	assign bit_n    = phase_q - PH_FIRST;
	assign byte_idx = IDX_W'(bit_n >> 3);

	always_comb begin
		rd_byte = '0;
		for (int k = 0; k < FRAME_BYTES; k++) begin
			if (byte_idx == IDX_W'(k)) begin
				rd_byte = store_q[k];
			end
		end
	end

	always_comb begin
		nxt_phase = phase_q;
		st        = ST_ARMED;
		new_byte  = {1'b0, rd_byte[7:1]};
		wr_en     = 1'b0;
		done      = 1'b0;
		priority if (phase_q == PH_LEADER) begin
			if (hit.leader) begin
				nxt_phase = PH_FIRST;
				st        = ST_LEADER;
			end else begin
				st = ST_NO_LEADER;
			end
		end else if (phase_q >= PH_FIRST && phase_q <= LAST_PHASE) begin
			wr_en = 1'b1;
			// zero window wins where the two overlap; a bad bit still shifts in a 0
			priority if (hit.zero) begin
				st = ST_BIT;
			end else if (hit.one) begin
				new_byte = {1'b1, rd_byte[7:1]};
				st       = ST_BIT;
			end else begin
				st = ST_BAD_BIT;
			end
			priority if (st == ST_BAD_BIT) begin
				nxt_phase = PH_IDLE;
			end else if (phase_q == LAST_PHASE) begin
				nxt_phase = PH_IDLE;
				st        = ST_DONE;
				done      = 1'b1;
			end else begin
				nxt_phase = phase_q + PHASE_W'(1);
			end
		end else begin
			nxt_phase = PH_LEADER;
			st        = ST_ARMED;
		end
	end

	// frame assembly, with the byte being finished taken from the shifter
	always_comb begin
		lo_d = '0;
		hi_d = '0;
		if (done) begin
			for (int k = 0; k < FRAME_BYTES; k++) begin
				if (k < 8) begin
					lo_d[8*k +: 8] = (byte_idx == IDX_W'(k)) ? new_byte : store_q[k];
				end else begin
					hi_d[8*(k-8) +: 8] = (byte_idx == IDX_W'(k)) ? new_byte : store_q[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q     <= nxt_phase;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q     <= st;
			frame_low_q  <= lo_d;
			frame_high_q <= hi_d;
			if (wr_en) begin
				store_q[byte_idx] <= new_byte;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign frame_low  = frame_low_q;
	assign frame_high = frame_high_q;

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= LAST_PHASE)
		else $error("phase counter beyond last data bit");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (done || st == ST_BAD_BIT) |=> phase_q == PH_IDLE)
		else $error("frame end or abort did not return to idle");

	a_leader_next: assert property (@(posedge clk) disable iff (!arst_n)
		advance && st == ST_LEADER |=> phase_q == PH_FIRST)
		else $error("leader accepted but data phase not entered");

	a_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_DONE |-> frame_low_q == '0 && frame_high_q == '0)
		else $error("frame data shown without frame complete");

endmodule

@@ tb/tb_top.sv @@
// Testbench for the IR pulse-distance frame decoder: predictor, stimulus and result checks.
module tb_top import irpd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBYTES       = FRAME_BYTES_DEF;
	localparam int PHASE_ITEMS  = 80;
	localparam int DRAIN_CYCLES = 4;
	localparam int MAX_WAIT     = 18;

	localparam logic [PHASE_W-1:0] PH_IDLE        = 7'd0;
	localparam logic [PHASE_W-1:0] PH_LEADER_WAIT = 7'd1;
	localparam logic [PHASE_W-1:0] PH_FIRST_BIT   = 7'd2;
	localparam logic [PHASE_W-1:0] PH_LAST_BIT    = 7'(2 + NBYTES * 8 - 1);

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	// nominal timings: 9 ms + 4.5 ms leader, 1.12 ms zero, 2.24 ms one
	localparam logic [TICK_W-1:0] NOMINAL_LEADER = 16'd13460;
	localparam logic [TICK_W-1:0] NOMINAL_ZERO   = 16'd1120;
	localparam logic [TICK_W-1:0] NOMINAL_ONE    = 16'd2236;

	typedef struct {
		status_t                 code;
		logic [FRAME_LO_W-1:0]   lo;
		logic [FRAME_HI_W-1:0]   hi;
	} decode_result_t;

	class frame_scoreboard;
		win_cfg_t                win;
		logic [PHASE_W-1:0]      phase;
		logic [7:0]              frame_bytes [NBYTES];
		decode_result_t          expected_q [$];
		int                      errors;
		int                      frames_done;
		int                      aborts;
		int                      leader_misses;

		function new();
			win = '{LEADER_MIN_RST, LEADER_MAX_RST, ZERO_MIN_RST, ZERO_MAX_RST,
				ONE_MIN_RST, ONE_MAX_RST};
			phase = PH_IDLE;
			foreach (frame_bytes[k])
				frame_bytes[k] = '0;
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [TICK_W-1:0] d);
			case (idx)
				REG_LEADER_MIN: win.leader_min = d;
				REG_LEADER_MAX: win.leader_max = d;
				REG_ZERO_MIN:   win.zero_min = d;
				REG_ZERO_MAX:   win.zero_max = d;
				REG_ONE_MIN:    win.one_min = d;
				REG_ONE_MAX:    win.one_max = d;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// advance the decoder state by one interval and queue the status it must report
		function void note_interval(input logic [TICK_W-1:0] t);
			decode_result_t r;
			int idx;
			int k;
			logic [7:0] b;
			r.code = ST_ARMED;
			r.lo = '0;
			r.hi = '0;
			if (phase == PH_LEADER_WAIT) begin
				if (t >= win.leader_min && t <= win.leader_max) begin
					phase = PH_FIRST_BIT;
					r.code = ST_LEADER;
				end else begin
					r.code = ST_NO_LEADER;
					leader_misses++;
				end
			end else if (phase >= PH_FIRST_BIT && phase <= PH_LAST_BIT) begin
				idx = int'(phase - PH_FIRST_BIT) >> 3;
				b = frame_bytes[idx] >> 1;
				// zero window wins where the two overlap
				if (t >= win.zero_min && t <= win.zero_max) begin
					r.code = ST_BIT;
				end else if (t >= win.one_min && t <= win.one_max) begin
					b[7] = 1'b1;
					r.code = ST_BIT;
				end else begin
					r.code = ST_BAD_BIT;
				end
				frame_bytes[idx] = b;
				if (r.code == ST_BAD_BIT) begin
					phase = PH_IDLE;
					aborts++;
				end else if (phase == PH_LAST_BIT) begin
					phase = PH_IDLE;
					r.code = ST_DONE;
					frames_done++;
					for (k = 0; k < NBYTES; k++) begin
						if (k < 8)
							r.lo[8*k +: 8] = frame_bytes[k];
						else
							r.hi[8*(k-8) +: 8] = frame_bytes[k];
					end
				end else begin
					phase = phase + 7'd1;
				end
			end else begin
				phase = PH_LEADER_WAIT;
			end
			expected_q.push_back(r);
		endfunction

		function void check_result(input logic [2:0] st, input logic [FRAME_LO_W-1:0] lo,
			input logic [FRAME_HI_W-1:0] hi);
			decode_result_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, status %0d", $time, st);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (st !== e.code) begin
				$display("%0t: status expected %0d got %0d", $time, e.code, st);
				errors++;
			end
			if (lo !== e.lo) begin
				$display("%0t: frame_low expected %h got %h", $time, e.lo, lo);
				errors++;
			end
			if (hi !== e.hi) begin
				$display("%0t: frame_high expected %h got %h", $time, e.hi, hi);
				errors++;
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [TICK_W-1:0]       interval_ticks = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [2:0]              status;
	logic [FRAME_LO_W-1:0]   frame_low;
	logic [FRAME_HI_W-1:0]   frame_high;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [TICK_W-1:0]       cfg_data = '0;

	frame_scoreboard sb = new();
	bit in_calm;
	bit out_calm;
	int items_sent;
	int settings_used;

	always #2 clk = ~clk;

	ir_pulse_distance_frame_decoder #(.FRAME_BYTES(NBYTES)) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.interval_ticks (interval_ticks),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.frame_low      (frame_low),
		.frame_high     (frame_high),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// idle cycles before the next transfer; calm stretches have none
	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(39, 0) == 0)
			calm = !calm;
		return calm ? 0 : int'($urandom_range(MAX_WAIT, 0));
	endfunction

	function automatic logic [TICK_W-1:0] pick_in(input logic [TICK_W-1:0] lo, hi);
		case ($urandom_range(3, 0))
			0: return lo;
			1: return hi;
			default: return TICK_W'($urandom_range(hi, lo));
		endcase
	endfunction

	function automatic bit is_bit(input logic [TICK_W-1:0] v);
		return (v >= sb.win.zero_min && v <= sb.win.zero_max) ||
			(v >= sb.win.one_min && v <= sb.win.one_max);
	endfunction

	function automatic logic [TICK_W-1:0] pick_bit();
		bit zero_ok;
		bit one_ok;
		zero_ok = sb.win.zero_min <= sb.win.zero_max;
		one_ok = sb.win.one_min <= sb.win.one_max;
		if (zero_ok && (!one_ok || $urandom_range(1, 0) == 0))
			return pick_in(sb.win.zero_min, sb.win.zero_max);
		if (one_ok)
			return pick_in(sb.win.one_min, sb.win.one_max);
		return TICK_W'($urandom);
	endfunction

	function automatic bit pick_bad_bit(output logic [TICK_W-1:0] v);
		int tries;
		for (tries = 0; tries < 40; tries++) begin
			case ($urandom_range(4, 0))
				0: v = sb.win.zero_min - 16'd1;
				1: v = sb.win.zero_max + 16'd1;
				2: v = sb.win.one_min - 16'd1;
				3: v = sb.win.one_max + 16'd1;
				default: v = TICK_W'($urandom);
			endcase
			if (!is_bit(v))
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit pick_no_leader(output logic [TICK_W-1:0] v);
		logic [TICK_W-1:0] lo;
		logic [TICK_W-1:0] hi;
		lo = sb.win.leader_min;
		hi = sb.win.leader_max;
		v = TICK_W'($urandom);
		if (lo > hi)
			return 1'b1;
		if (lo == 0 && hi == 16'hFFFF)
			return 1'b0;
		if (lo > 0 && (hi == 16'hFFFF || $urandom_range(1, 0) == 0))
			v = ($urandom_range(1, 0) == 0) ? lo - 16'd1 :
				TICK_W'($urandom_range(lo - 1, 0));
		else
			v = ($urandom_range(1, 0) == 0) ? hi + 16'd1 :
				TICK_W'($urandom_range(16'hFFFF, hi + 1));
		return 1'b1;
	endfunction

	task automatic send_interval(input logic [TICK_W-1:0] v);
		int gap;
		gap = draw_wait(in_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		interval_ticks <= v;
		do @(posedge clk); while (in_stall);
		sb.note_interval(v);
		items_sent++;
		@(negedge clk);
	endtask

	// well-formed frame with random content, sometimes with leader misses or a bad bit
	task automatic run_frame();
		logic [TICK_W-1:0] v;
		int misses;
		int bad_at;
		int i;
		while (sb.phase != PH_LEADER_WAIT) begin
			if (sb.phase == PH_IDLE)
				send_interval(TICK_W'($urandom));
			else
				send_interval(pick_bit());
		end
		misses = ($urandom_range(3, 0) == 0) ? int'($urandom_range(3, 1)) : 0;
		repeat (misses)
			if (pick_no_leader(v))
				send_interval(v);
		if (sb.win.leader_min > sb.win.leader_max) begin
			send_interval(TICK_W'($urandom));
			return;
		end
		send_interval(pick_in(sb.win.leader_min, sb.win.leader_max));
		bad_at = ($urandom_range(4, 0) == 0) ? int'($urandom_range(NBYTES * 8 - 1, 0)) : -1;
		for (i = 0; i < NBYTES * 8; i++) begin
			if (i == bad_at && pick_bad_bit(v)) begin
				send_interval(v);
				return;
			end
			send_interval(pick_bit());
		end
	endtask

	task automatic run_random(input int count);
		int stop;
		stop = items_sent + count;
		while (items_sent < stop) begin
			if ($urandom_range(4, 0) == 0)
				repeat ($urandom_range(6, 1))
					send_interval(TICK_W'($urandom));
			else
				run_frame();
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] d,
		input bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, d);
		@(negedge clk);
		if (last)
			cfg_valid <= 1'b0;
	endtask

	task automatic load_windows(input win_cfg_t w, input bit last);
		write_reg(REG_LEADER_MIN, w.leader_min, 1'b0);
		write_reg(REG_LEADER_MAX, w.leader_max, 1'b0);
		write_reg(REG_ZERO_MIN, w.zero_min, 1'b0);
		write_reg(REG_ZERO_MAX, w.zero_max, 1'b0);
		write_reg(REG_ONE_MIN, w.one_min, 1'b0);
		write_reg(REG_ONE_MAX, w.one_max, last);
		settings_used++;
	endtask

	initial begin
		logic [TICK_W-1:0] directed [$];
		win_cfg_t plan [$];
		win_cfg_t w;
		int p;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		settings_used = 1;

		// window edges, every status but frame done, abort followed by a swallowed interval
		directed = '{16'hFFFF, 16'h0000, 16'hFFFF, LEADER_MIN_RST - 16'd1,
			LEADER_MAX_RST + 16'd1, LEADER_MIN_RST, ZERO_MIN_RST, ZERO_MAX_RST,
			ONE_MIN_RST, ONE_MAX_RST, ZERO_MAX_RST + 16'd1, LEADER_MIN_RST,
			LEADER_MAX_RST, ONE_MAX_RST + 16'd1, 16'h0000, NOMINAL_LEADER,
			ZERO_MIN_RST - 16'd1, NOMINAL_ONE, LEADER_MAX_RST, ONE_MIN_RST - 16'd1,
			16'h8000, LEADER_MIN_RST, 16'hFFFF, NOMINAL_ZERO, NOMINAL_LEADER};
		foreach (directed[k])
			send_interval(directed[k]);
		run_random(PHASE_ITEMS);

		w.leader_min = TICK_W'($urandom_range(60000, 0));
		w.leader_max = w.leader_min + TICK_W'($urandom_range(5000, 0));
		w.zero_min = TICK_W'($urandom_range(30000, 0));
		w.zero_max = w.zero_min + TICK_W'($urandom_range(3000, 0));
		w.one_min = TICK_W'($urandom_range(60000, 0));
		w.one_max = w.one_min + TICK_W'($urandom_range(5000, 0));
		plan = '{
			// everything is a leader, bit value follows the MSB
			'{16'h0000, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF},
			// overlapping bit windows
			'{16'd12000, 16'd15000, 16'd900, 16'd2500, 16'd2000, 16'd2600},
			// empty zero window, single-value leader
			'{NOMINAL_LEADER, NOMINAL_LEADER, 16'hFFFF, 16'h0000, 16'h0000, 16'd3000},
			// empty one window, leader at the top of the range
			'{16'hFFFF, 16'hFFFF, ZERO_MIN_RST, ZERO_MAX_RST, 16'hFFFF, 16'hFFFE},
			w,
			// one-tick windows at both ends of the range
			'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF},
			'{LEADER_MIN_RST, LEADER_MAX_RST, ZERO_MIN_RST, ZERO_MAX_RST,
				ONE_MIN_RST, ONE_MAX_RST}
		};
		for (p = 0; p < plan.size(); p++) begin
			drain();
			load_windows(plan[p], p != 0);
			// indexes past the last register must leave the windows alone
			if (p == 0) begin
				write_reg(REG_SPARE_6, TICK_W'($urandom), 1'b0);
				write_reg(REG_SPARE_7, TICK_W'($urandom), 1'b1);
			end
			run_random(PHASE_ITEMS);
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Sent %0d intervals under %0d window settings:",
			items_sent, settings_used);
		$display("  %0d frames, %0d aborts, %0d leader misses",
			sb.frames_done, sb.aborts, sb.leader_misses);
		if (sb.errors == 0)
			$display("ir_pulse_distance_frame_decoder test passed");
		else
			$display("ir_pulse_distance_frame_decoder test failed");
		$finish;
	end

	initial begin : result_side
		int n;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			n = draw_wait(out_calm);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			sb.check_result(status, frame_low, frame_high);
			@(negedge clk);
		end
	end

	initial begin
		#2_000_000;
		$display("ir_pulse_distance_frame_decoder test failed");
		$finish;
	end

endmodule
